// ----- hw/rtl/wfc_pkg.sv -----
// Shared types and codes for the word frequency counter.
package wfc_pkg;

   localparam int WORDS_DEFAULT      = 512;
   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int WORD_CHARS         = 12;
   localparam int WORD_BITS          = 96;

   localparam logic [1:0] OP_TEXT = 2'd0;
   localparam logic [1:0] OP_END  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [1:0] KIND_COUNTED = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_DROPPED = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] char_in;
      logic [8:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [8:0]  entry;
      logic [15:0] count;
      logic        is_new;
      logic [63:0] word_low;
      logic [31:0] word_high;
      logic [9:0]  distinct_words;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic                 is_read;
      logic [WORD_BITS-1:0] word;
      logic [8:0]           index;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

endpackage

// ----- hw/rtl/wfc_engine.sv -----
// Word table memory with the sequencer that searches, updates and reads it.
module wfc_engine #(
   parameter int WORDS      = wfc_pkg::WORDS_DEFAULT,
   parameter int COUNT_BITS = wfc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  wfc_pkg::cmd_type cmd,
   output logic             busy,
   output wfc_pkg::res_type res
);
   import wfc_pkg::*;

   localparam int IDX_W = $clog2(WORDS);
   localparam int CNT_W = $clog2(WORDS + 1);

   typedef struct packed {
      logic [WORD_BITS-1:0]  word;
      logic [COUNT_BITS-1:0] count;
   } row_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_RDOUT  = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_INSERT = 6'b100000
   } state_type;

   row_type mem [WORDS];
   row_type rdata_ff;
   logic             rd_en;
   logic [IDX_W-1:0] raddr;
   logic             we;
   logic [IDX_W-1:0] waddr;
   row_type          wdata;

   state_type             state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic                  overflow_ff, overflow_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;

   logic                  row_ok;
   logic                  issue;
   logic                  match;
   logic                  full;
   logic [COUNT_BITS-1:0] sat_cnt;
   logic [CNT_W-1:0]      used_next;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign row_ok    = 32'(cmd_ff.index) < 32'(used_ff);
   assign issue     = rd_idx_ff < used_ff;
   assign match     = cmp_valid_ff && (rdata_ff.word == cmd_ff.word);
   assign full      = used_ff == CNT_W'(WORDS);
   assign sat_cnt   = (&hit_cnt_ff) ? hit_cnt_ff : hit_cnt_ff + COUNT_BITS'(1);
   assign used_next = used_ff + CNT_W'(1);
   assign busy      = state_ff != ST_IDLE;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      used_in      = used_ff;
      overflow_in  = overflow_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      hit_idx_in   = hit_idx_ff;
      hit_cnt_in   = hit_cnt_ff;
      rd_en        = 1'b0;
      raddr        = rd_idx_ff[IDX_W-1:0];
      we           = 1'b0;
      waddr        = hit_idx_ff;
      wdata.word   = cmd_ff.word;
      wdata.count  = sat_cnt;
      res.valid               = 1'b0;
      res.data.kind           = KIND_COUNTED;
      res.data.entry          = 9'(hit_idx_ff);
      res.data.count          = 16'(sat_cnt);
      res.data.is_new         = 1'b0;
      res.data.word_low       = cmd_ff.word[63:0];
      res.data.word_high      = cmd_ff.word[95:64];
      res.data.distinct_words = 10'(used_ff);
      res.data.overflow       = overflow_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               cmd_in       = cmd;
               rd_idx_in    = '0;
               cmp_valid_in = 1'b0;
               state_in     = cmd.is_read ? ST_READ : ST_SCAN;
            end
         end
         ST_READ: begin
            rd_en    = row_ok;
            raddr    = IDX_W'(cmd_ff.index);
            state_in = ST_RDOUT;
         end
         ST_RDOUT: begin
            res.valid      = 1'b1;
            res.data.kind  = KIND_READ;
            res.data.entry = cmd_ff.index;
            if (row_ok) begin
               res.data.count     = 16'(rdata_ff.count);
               res.data.word_low  = rdata_ff.word[63:0];
               res.data.word_high = rdata_ff.word[95:64];
            end else begin
               res.data.count     = '0;
               res.data.word_low  = '0;
               res.data.word_high = '0;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            rd_en = issue;
            if (match) begin
               hit_idx_in = cmp_idx_ff;
               hit_cnt_in = rdata_ff.count;
               state_in   = ST_UPDATE;
            end else if (!issue && !cmp_valid_ff) begin
               state_in = ST_INSERT;
            end else begin
               rd_idx_in    = rd_idx_ff + CNT_W'(issue);
               cmp_valid_in = issue;
               cmp_idx_in   = rd_idx_ff[IDX_W-1:0];
            end
         end
         ST_UPDATE: begin
            we        = 1'b1;
            res.valid = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_INSERT: begin
            res.valid = 1'b1;
            if (!full) begin
               we                      = 1'b1;
               waddr                   = used_ff[IDX_W-1:0];
               wdata.count             = COUNT_BITS'(1);
               used_in                 = used_next;
               res.data.entry          = 9'(used_ff);
               res.data.count          = 16'd1;
               res.data.is_new         = 1'b1;
               res.data.distinct_words = 10'(used_next);
            end else begin
               overflow_in       = 1'b1;
               res.data.kind     = KIND_DROPPED;
               res.data.entry    = '0;
               res.data.count    = '0;
               res.data.overflow = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         overflow_ff  <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         overflow_ff  <= overflow_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_idx_ff <= hit_idx_in;
      hit_cnt_ff <= hit_cnt_in;
   end

endmodule

// ----- hw/rtl/word_frequency_counter_unit.sv -----
// Top level of the word frequency counter.
// Text bytes are taken one per cycle and build the pending word. A byte that ends a
// word, an end of text with a pending word, or a read starts the table engine, and the
// input stalls until it finishes. A word end runs a search that reads the table memory
// one entry per cycle through its single read port; a read passes through the states
// ST_READ and ST_RDOUT in turn. Results wait in an output register, and text
// bytes that finish no word are still taken while a result waits there. Entries that
// were never written read as zero, since only entries below the fill count are valid.
module word_frequency_counter_unit #(
   parameter int WORDS      = wfc_pkg::WORDS_DEFAULT,
   parameter int COUNT_BITS = wfc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wfc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wfc_pkg::rsp_type rsp_data
);
   import wfc_pkg::*;

   localparam int LEN_W = $clog2(WORD_CHARS + 1);

   function automatic logic is_delim(input logic [7:0] c);
      logic d;
      case (c)
         8'h00, 8'h20, 8'h0a, 8'h22, 8'h2e, 8'h2c,
         8'h3b, 8'h3a, 8'h21, 8'h3f, 8'h28, 8'h29: d = 1'b1;
         default: d = 1'b0;
      endcase
      return d;
   endfunction

   logic [WORD_BITS-1:0] pending_word_ff, pending_word_in;
   logic [LEN_W-1:0]     pending_len_ff, pending_len_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic    delim;
   logic    ends_word;
   logic    wants_engine;
   logic    out_free;
   logic    accept;
   logic    eng_busy;
   cmd_type cmd;
   res_type res;

   assign delim        = is_delim(req_data.char_in);
   assign ends_word    = (pending_len_ff != '0)
                         && ((req_data.op == OP_TEXT && delim) || req_data.op == OP_END);
   assign wants_engine = ends_word || req_data.op == OP_READ;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = eng_busy || (wants_engine && !out_free);
   assign accept       = req_valid && !req_stall;

   assign cmd.start   = accept && wants_engine;
   assign cmd.is_read = req_data.op == OP_READ;
   assign cmd.word    = pending_word_ff;
   assign cmd.index   = req_data.entry_index;

   wfc_engine #(
      .WORDS      (WORDS),
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .busy  (eng_busy),
      .res   (res)
   );

   always_comb begin
      pending_word_in = pending_word_ff;
      pending_len_in  = pending_len_ff;
      if (accept && ends_word) begin
         pending_word_in = '0;
         pending_len_in  = '0;
      end else if (accept && req_data.op == OP_TEXT && !delim
                   && pending_len_ff < LEN_W'(WORD_CHARS)) begin
         pending_word_in[8*pending_len_ff +: 8] = req_data.char_in;
         pending_len_in = pending_len_ff + LEN_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.data;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_word_ff <= '0;
         pending_len_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pending_word_ff <= pending_word_in;
         pending_len_ff  <= pending_len_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/wfc_checker.sv -----
// Port-level checks for the word frequency counter and their binding.
module wfc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input wfc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input wfc_pkg::rsp_type rsp_data
);
   import wfc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("A stalled result transaction changed or vanished.");

   a_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_DROPPED
      |-> rsp_data.overflow && rsp_data.entry == '0 && rsp_data.count == '0)
      else $error("A dropped word did not report overflow with a cleared entry.");

   a_new_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_new
      |-> rsp_data.kind == KIND_COUNTED && rsp_data.count == 16'd1)
      else $error("A newly added word did not report a count of one.");

   a_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_COUNTED
      |-> rsp_data.count != '0 && rsp_data.distinct_words != '0)
      else $error("A counted word reported an empty entry or an empty table.");

endmodule

bind word_frequency_counter_unit wfc_checker u_checker (.*);
